@@ rtl/three_button_debounce_short_hold_macros.svh @@
// Assertion macros for the three-button debouncer.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef THREE_BUTTON_DEBOUNCE_SHORT_HOLD_MACROS_SVH
`define THREE_BUTTON_DEBOUNCE_SHORT_HOLD_MACROS_SVH

// Checked on every edge, reset included.
`define TBDSH_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

// Checked only while out of reset.
`define TBDSH_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`endif

@@ rtl/tbdsh_pkg.sv @@
// Shared types and constants for the three-button debouncer.
// No dependencies.
`timescale 1ns / 1ps

package tbdsh_pkg;

  localparam int TimeBits    = 32;
  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 16;
  localparam int MsBits      = 16;
  localparam int BitSelBits  = 3;
  localparam int PortBits    = 8;

  // register indexes
  localparam logic [CfgIdxBits-1:0] CfgDebounce  = 3'd0;
  localparam logic [CfgIdxBits-1:0] CfgBtnHold   = 3'd1;
  localparam logic [CfgIdxBits-1:0] CfgPwrHold   = 3'd2;
  localparam logic [CfgIdxBits-1:0] CfgFirstBit  = 3'd3;
  localparam logic [CfgIdxBits-1:0] CfgSecondBit = 3'd4;
  localparam logic [CfgIdxBits-1:0] CfgPowerBit  = 3'd5;

  // register reset values
  localparam logic [MsBits-1:0]     DebounceReset = 16'd30;
  localparam logic [MsBits-1:0]     BtnHoldReset  = 16'd1000;
  localparam logic [MsBits-1:0]     PwrHoldReset  = 16'd3000;
  localparam logic [BitSelBits-1:0] FirstBitReset  = 3'd0;
  localparam logic [BitSelBits-1:0] SecondBitReset = 3'd1;
  localparam logic [BitSelBits-1:0] PowerBitReset  = 3'd2;

  // request types
  localparam logic ReqTick = 1'b0;
  localparam logic ReqInit = 1'b1;

  typedef enum logic [1:0] {
    PressNone  = 2'd0,
    PressShort = 2'd1,
    PressHold  = 2'd2
  } press_e;

  typedef enum logic [2:0] {
    EvNone     = 3'd0,
    EvPwrShort = 3'd1,
    EvPwrHold  = 3'd2,
    EvB1Short  = 3'd3,
    EvB1Hold   = 3'd4,
    EvB2Short  = 3'd5,
    EvB2Hold   = 3'd6
  } event_e;

  // per-button control from the top level
  typedef struct packed {
    logic fire;      // a word is processed this cycle
    logic init;      // the word is an init request
    logic judge_en;  // classification allowed (no earlier event)
  } btn_ctrl_t;

endpackage

@@ rtl/three_button_debounce_short_hold.sv @@
// Three-button debouncer with short-press and hold detection: top level.
// Depends on tbdsh_pkg, tbdsh_button and the assertion macro header.
`timescale 1ns / 1ps
`include "three_button_debounce_short_hold_macros.svh"

// Takes one word per clock unless in_stall_o is high: each word carries
// a ms timestamp and an active-low 8-bit port sample (low = pressed) and
// yields exactly one event code. A word waits in the input register, is
// evaluated against the per-button state on its way into the result
// register, and is offered on the output the cycle after; throughput is
// one word per cycle while the output side keeps taking.
// The output register decouples the two sides: a new word is accepted
// even while a finished result waits, as long as the input register can
// move on. Tick words (req_type 0) debounce the power, button one and
// button two bits chosen by the bit-select registers; elapsed times use
// wrapping 32-bit subtraction. Power is classified first, then button
// one, then button two; only the first event is reported and later
// buttons skip that tick's press/hold bookkeeping (their stable levels
// still settle). Init words (req_type 1) load the sampled levels and
// report no event. A failed expander read should be fed as 0xFF.
// Configuration is written through cfg_we_i/cfg_index_i/cfg_data_i while
// the block is idle (the user's duty; the block does not enforce it); unknown indexes are ignored.
module three_button_debounce_short_hold
  import tbdsh_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input words
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   req_type_i,
  input  logic [TimeBits-1:0]    now_time_i,
  input  logic [PortBits-1:0]    port_bits_i,
  // result words
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [2:0]             event_code_o,
  // configuration
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_index_i,
  input  logic [CfgDataBits-1:0] cfg_data_i
);

  // ---- configuration registers ----
  logic [MsBits-1:0]     debounce_q, btn_hold_q, pwr_hold_q;
  logic [BitSelBits-1:0] first_bit_q, second_bit_q, power_bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DebounceReset;
      btn_hold_q   <= BtnHoldReset;
      pwr_hold_q   <= PwrHoldReset;
      first_bit_q  <= FirstBitReset;
      second_bit_q <= SecondBitReset;
      power_bit_q  <= PowerBitReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgDebounce:  debounce_q   <= cfg_data_i;
        CfgBtnHold:   btn_hold_q   <= cfg_data_i;
        CfgPwrHold:   pwr_hold_q   <= cfg_data_i;
        CfgFirstBit:  first_bit_q  <= cfg_data_i[BitSelBits-1:0];
        CfgSecondBit: second_bit_q <= cfg_data_i[BitSelBits-1:0];
        CfgPowerBit:  power_bit_q  <= cfg_data_i[BitSelBits-1:0];
        default: ;
      endcase
    end
  end

  // ---- input register ----
  logic                in_valid_q;
  logic                req_q;
  logic [TimeBits-1:0] now_q;
  logic [PortBits-1:0] port_q;

  // ---- result register ----
  logic   out_valid_q, out_valid_d;
  event_e event_q, event_d;

  logic advance;  // input register may move into the result register
  logic fire;     // a word is evaluated this cycle

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      req_q  <= req_type_i;
      now_q  <= now_time_i;
      port_q <= port_bits_i;
    end
  end

  // ---- button channels ----
  logic      lvl_one, lvl_two, lvl_pwr;
  press_e    res_one, res_two, res_pwr;
  btn_ctrl_t ctrl_one, ctrl_two, ctrl_pwr;
  logic      is_init;

  assign lvl_one = ~port_q[first_bit_q];
  assign lvl_two = ~port_q[second_bit_q];
  assign lvl_pwr = ~port_q[power_bit_q];
  assign is_init = (req_q == ReqInit);

  // priority: power, then button one, then button two
  always_comb begin
    ctrl_pwr = '{fire: fire, init: is_init, judge_en: 1'b1};
    ctrl_one = '{fire: fire, init: is_init, judge_en: (res_pwr == PressNone)};
    ctrl_two = '{fire: fire, init: is_init,
                 judge_en: (res_pwr == PressNone) && (res_one == PressNone)};
  end

  tbdsh_button u_btn_pwr (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl_pwr),
    .level_i    (lvl_pwr),
    .now_i      (now_q),
    .debounce_i (debounce_q),
    .hold_i     (pwr_hold_q),
    .result_o   (res_pwr)
  );

  tbdsh_button u_btn_one (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl_one),
    .level_i    (lvl_one),
    .now_i      (now_q),
    .debounce_i (debounce_q),
    .hold_i     (btn_hold_q),
    .result_o   (res_one)
  );

  tbdsh_button u_btn_two (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl_two),
    .level_i    (lvl_two),
    .now_i      (now_q),
    .debounce_i (debounce_q),
    .hold_i     (btn_hold_q),
    .result_o   (res_two)
  );

  // ---- event select ----
  always_comb begin
    event_d = EvNone;
    if (!is_init) begin
      case (res_pwr)
        PressShort: event_d = EvPwrShort;
        PressHold:  event_d = EvPwrHold;
        default: begin
          case (res_one)
            PressShort: event_d = EvB1Short;
            PressHold:  event_d = EvB1Hold;
            default: begin
              case (res_two)
                PressShort: event_d = EvB2Short;
                PressHold:  event_d = EvB2Hold;
                default:    event_d = EvNone;
              endcase
            end
          endcase
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      event_q <= event_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_code_o = event_q;

  // ---- assertions ----
  `TBDSH_ASSERT_CLK(a_stall_only_on_full_output, in_stall_o |-> (out_valid_o && out_stall_i), "input stalled while output free")
  `TBDSH_ASSERT_RST(a_init_reports_none, (fire && is_init) |=> (out_valid_o && event_code_o == EvNone), "init word produced an event")
  `TBDSH_ASSERT_RST(a_drain_empties, (out_valid_o && !out_stall_i && !in_valid_q) |=> !out_valid_o, "result repeated after it was taken")

endmodule

@@ rtl/tbdsh_button.sv @@
// One button channel: debounce state, press timing and classification.
// Depends on tbdsh_pkg.
`timescale 1ns / 1ps

module tbdsh_button
  import tbdsh_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  btn_ctrl_t           ctrl_i,
  input  logic                level_i,     // 1 = pressed
  input  logic [TimeBits-1:0] now_i,
  input  logic [MsBits-1:0]   debounce_i,
  input  logic [MsBits-1:0]   hold_i,
  output press_e              result_o
);

  logic                raw_q, raw_d;
  logic                stable_q, stable_d;
  logic                held_q, held_d;
  logic [TimeBits-1:0] change_q, change_d;
  logic [TimeBits-1:0] press_q, press_d;

  logic                raw_chg;
  logic [TimeBits-1:0] db_elapsed;
  logic [TimeBits-1:0] hold_elapsed;
  logic                stable_nx;
  logic                hold_due;
  logic                press_edge;

  always_comb begin
    raw_chg      = (level_i != raw_q);
    // a fresh change restarts the window at now, so elapsed is zero
    db_elapsed   = raw_chg ? '0 : (now_i - change_q);
    stable_nx    = (db_elapsed >= {{(TimeBits-MsBits){1'b0}}, debounce_i}) ? level_i : stable_q;
    hold_elapsed = now_i - press_q;
    hold_due     = !held_q && (hold_elapsed >= {{(TimeBits-MsBits){1'b0}}, hold_i});
    press_edge   = stable_nx && !stable_q;

    result_o = PressNone;
    if (stable_nx && stable_q && hold_due) begin
      result_o = PressHold;
    end else if (!stable_nx && stable_q && !held_q) begin
      result_o = PressShort;
    end
  end

  always_comb begin
    raw_d    = raw_q;
    stable_d = stable_q;
    held_d   = held_q;
    change_d = change_q;
    press_d  = press_q;
    if (ctrl_i.fire) begin
      if (ctrl_i.init) begin
        raw_d    = level_i;
        stable_d = level_i;
        change_d = now_i;
        press_d  = '0;
        held_d   = 1'b0;
      end else begin
        raw_d    = level_i;
        stable_d = stable_nx;
        if (raw_chg) begin
          change_d = now_i;
        end
        if (ctrl_i.judge_en) begin
          if (press_edge) begin
            press_d = now_i;
            held_d  = 1'b0;
          end else if (result_o == PressHold) begin
            held_d  = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q    <= 1'b0;
      stable_q <= 1'b0;
      held_q   <= 1'b0;
      change_q <= '0;
      press_q  <= '0;
    end else begin
      raw_q    <= raw_d;
      stable_q <= stable_d;
      held_q   <= held_d;
      change_q <= change_d;
      press_q  <= press_d;
    end
  end

endmodule

@@ sim/three_button_debounce_short_hold_checker.sv @@
// Scoreboard for the three-button debouncer: mirrors configuration writes,
// predicts one event code per accepted input word and checks result words.
// Depends on tbdsh_pkg.
`timescale 1ns / 1ps

module three_button_debounce_short_hold_checker
  import tbdsh_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic                   req_type_i,
  input  logic [TimeBits-1:0]    now_time_i,
  input  logic [PortBits-1:0]    port_bits_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic [2:0]             event_code_i,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_index_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  localparam int BtnOne = 0;
  localparam int BtnTwo = 1;
  localparam int BtnPwr = 2;

  logic [MsBits-1:0]     deb_limit;
  logic [MsBits-1:0]     bhold_limit;
  logic [MsBits-1:0]     phold_limit;
  logic [BitSelBits-1:0] bit_sel [3];

  logic                  raw_lvl    [3];
  logic                  stable_lvl [3];
  logic                  held_flag  [3];
  logic [TimeBits-1:0]   chg_stamp  [3];
  logic [TimeBits-1:0]   press_ms   [3];

  event_e expected_events [$];
  event_e want;
  int     errors = 0;

  // Press/hold bookkeeping for one button after its level has settled.
  function automatic press_e classify(input int k, input logic was,
                                      input logic [TimeBits-1:0] ts,
                                      input logic [MsBits-1:0] hold);
    logic [TimeBits-1:0] elapsed;
    elapsed = ts - press_ms[k];
    if (stable_lvl[k] && !was) begin
      press_ms[k]  = ts;
      held_flag[k] = 1'b0;
      return PressNone;
    end
    if (stable_lvl[k] && was) begin
      if (!held_flag[k] && elapsed >= TimeBits'(hold)) begin
        held_flag[k] = 1'b1;
        return PressHold;
      end
      return PressNone;
    end
    if (!stable_lvl[k] && was) return held_flag[k] ? PressNone : PressShort;
    return PressNone;
  endfunction

  function automatic event_e next_event(input logic req,
                                        input logic [TimeBits-1:0] ts,
                                        input logic [PortBits-1:0] port);
    logic                lvl [3];
    logic                was [3];
    logic [TimeBits-1:0] elapsed;
    press_e              r;
    int                  k;
    for (k = 0; k < 3; k++) lvl[k] = ~port[bit_sel[k]];
    if (req == ReqInit) begin
      for (k = 0; k < 3; k++) begin
        raw_lvl[k]    = lvl[k];
        stable_lvl[k] = lvl[k];
        chg_stamp[k]  = ts;
        press_ms[k]   = '0;
        held_flag[k]  = 1'b0;
      end
      return EvNone;
    end
    for (k = 0; k < 3; k++) begin
      was[k] = stable_lvl[k];
      if (lvl[k] != raw_lvl[k]) begin
        raw_lvl[k]   = lvl[k];
        chg_stamp[k] = ts;
      end
      elapsed = ts - chg_stamp[k];
      if (elapsed >= TimeBits'(deb_limit)) stable_lvl[k] = lvl[k];
    end
    // first event wins; later buttons skip their bookkeeping
    r = classify(BtnPwr, was[BtnPwr], ts, phold_limit);
    if (r == PressHold)  return EvPwrHold;
    if (r == PressShort) return EvPwrShort;
    r = classify(BtnOne, was[BtnOne], ts, bhold_limit);
    if (r == PressHold)  return EvB1Hold;
    if (r == PressShort) return EvB1Short;
    r = classify(BtnTwo, was[BtnTwo], ts, bhold_limit);
    if (r == PressHold)  return EvB2Hold;
    if (r == PressShort) return EvB2Short;
    return EvNone;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_limit       = DebounceReset;
      bhold_limit     = BtnHoldReset;
      phold_limit     = PwrHoldReset;
      bit_sel[BtnOne] = FirstBitReset;
      bit_sel[BtnTwo] = SecondBitReset;
      bit_sel[BtnPwr] = PowerBitReset;
      for (int k = 0; k < 3; k++) begin
        raw_lvl[k]    = 1'b0;
        stable_lvl[k] = 1'b0;
        held_flag[k]  = 1'b0;
        chg_stamp[k]  = '0;
        press_ms[k]   = '0;
      end
      expected_events.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgDebounce:  deb_limit       = cfg_data_i;
          CfgBtnHold:   bhold_limit     = cfg_data_i;
          CfgPwrHold:   phold_limit     = cfg_data_i;
          CfgFirstBit:  bit_sel[BtnOne] = cfg_data_i[BitSelBits-1:0];
          CfgSecondBit: bit_sel[BtnTwo] = cfg_data_i[BitSelBits-1:0];
          CfgPowerBit:  bit_sel[BtnPwr] = cfg_data_i[BitSelBits-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_events.size() == 0) begin
          errors++;
          $display("%0t ns: stray result word, expected none, got event_code %0d",
                   $time, event_code_i);
        end else begin
          want = expected_events.pop_front();
          if (event_code_i !== want) begin
            errors++;
            $display("%0t ns: event_code mismatch, expected %0d, got %0d",
                     $time, want, event_code_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_events.push_back(next_event(req_type_i, now_time_i, port_bits_i));
    end
    pending_o    <= expected_events.size();
    fail_count_o <= errors;
  end

endmodule

@@ sim/tb_three_button_debounce_short_hold.sv @@
// Testbench top for the three-button debouncer: clock, reset, stimulus and verdict.
// Depends on tbdsh_pkg, the DUT and three_button_debounce_short_hold_checker.
`timescale 1ns / 1ps

module tb_three_button_debounce_short_hold;
  import tbdsh_pkg::*;

  // indexes with no register behind them; writes there must be dropped
  localparam logic [CfgIdxBits-1:0] CfgSpareLo = 3'd6;
  localparam logic [CfgIdxBits-1:0] CfgSpareHi = 3'd7;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  logic                   req_type_i  = ReqTick;
  logic [TimeBits-1:0]    now_time_i  = '0;
  logic [PortBits-1:0]    port_bits_i = '1;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [2:0]             event_code_o;
  logic                   cfg_we_i    = 1'b0;
  logic [CfgIdxBits-1:0]  cfg_index_i = '0;
  logic [CfgDataBits-1:0] cfg_data_i  = '0;

  int fail_count;
  int pending;

  // stimulus bookkeeping
  logic [TimeBits-1:0]   clock_ms;     // running ms timestamp fed to the block
  logic [BitSelBits-1:0] sel [3];      // current bit selects: one, two, power
  int                    tx_idle_pct = 0;
  int                    rx_idle_pct = 0;
  int                    words_sent  = 0;

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  three_button_debounce_short_hold dut (.*);

  three_button_debounce_short_hold_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .req_type_i   (req_type_i),
    .now_time_i   (now_time_i),
    .port_bits_i  (port_bits_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .event_code_i (event_code_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Receiver back-pressure: a fresh coin every cycle at the current rate.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_idle_pct);
  end

  // Offer one word and hold it until taken. Valid stays high on return so a
  // back-to-back word needs no second assignment in the same step; an idle
  // gap lowers it here, at the acceptance edge.
  task automatic send_word(input logic req, input logic [TimeBits-1:0] ts,
                           input logic [PortBits-1:0] port);
    // idling schedule: sender light / receiver heavy, then swapped, then none
    if (words_sent < 285) begin
      tx_idle_pct = 11;
      rx_idle_pct = 68;
    end else if (words_sent < 570) begin
      tx_idle_pct = 68;
      rx_idle_pct = 11;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    now_time_i  <= ts;
    port_bits_i <= port;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
    // one coin per cycle, so the idle share of cycles matches the rate
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait until every result word has come back. Every word
  // yields exactly one result, so an empty scoreboard means an idle block.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx,
                           input logic [CfgDataBits-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
  endtask

  // Full register set, written only once the block has gone quiet. Bit
  // selects carry junk in the upper data bits, which the block must drop.
  task automatic configure(input logic [MsBits-1:0] deb, input logic [MsBits-1:0] bhold,
                           input logic [MsBits-1:0] phold, input logic [BitSelBits-1:0] b1,
                           input logic [BitSelBits-1:0] b2, input logic [BitSelBits-1:0] pw);
    drain();
    write_reg(CfgDebounce, deb);
    write_reg(CfgBtnHold, bhold);
    write_reg(CfgPwrHold, phold);
    write_reg(CfgFirstBit, {13'($urandom), b1});
    write_reg(CfgSecondBit, {13'($urandom), b2});
    write_reg(CfgPowerBit, {13'($urandom), pw});
    write_reg(($urandom_range(1) != 0) ? CfgSpareLo : CfgSpareHi, 16'($urandom));
    cfg_we_i <= 1'b0;
    sel[0] = b1;
    sel[1] = b2;
    sel[2] = pw;
  endtask

  // Gesture-style traffic: a pressed-button mask is held for a run of ticks
  // while time creeps forward, so debounce, press, hold and release all get
  // exercised. Sprinkled on top: single-tick bounces, wild time/port jumps
  // and init words.
  task automatic random_phase(input int n, input int unsigned max_step);
    logic [2:0]          intent;
    logic [PortBits-1:0] port;
    logic                req;
    int                  run_left;
    int unsigned         roll;
    int                  k;
    intent   = '0;
    run_left = 0;
    for (int i = 0; i < n; i++) begin
      if (run_left == 0) begin
        intent   = 3'($urandom_range(0, 7));
        run_left = $urandom_range(1, 24);
      end
      run_left--;
      req  = ReqTick;
      port = 8'($urandom);
      // pressed reads low; power applied last when selects collide
      port[sel[0]] = ~intent[0];
      port[sel[1]] = ~intent[1];
      port[sel[2]] = ~intent[2];
      clock_ms += $urandom_range(0, max_step);
      roll = $urandom_range(99);
      if (roll < 8) begin
        k = $urandom_range(0, 2);
        port[sel[k]] = ~port[sel[k]];
      end else if (roll < 12) begin
        clock_ms = $urandom;
        port     = 8'($urandom);
      end else if (roll < 14) begin
        req = ReqInit;
      end
      send_word(req, clock_ms, port);
    end
  endtask

  initial begin
    sel[0] = FirstBitReset;
    sel[1] = SecondBitReset;
    sel[2] = PowerBitReset;
    clock_ms = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words at the reset configuration (30 ms debounce, 1 s button
    // hold, 3 s power hold, bits 0/1/2).
    send_word(ReqInit, 32'd1000, 8'hFF);
    send_word(ReqTick, 32'd1010, 8'hFB);        // power goes down, not settled yet
    send_word(ReqTick, 32'd1040, 8'hFB);        // settled: press edge
    send_word(ReqTick, 32'd2000, 8'hFB);
    send_word(ReqTick, 32'd4040, 8'hFB);        // power hold
    send_word(ReqTick, 32'd4100, 8'hFF);
    send_word(ReqTick, 32'd4130, 8'hFF);        // release after hold: silent
    send_word(ReqTick, 32'd4200, 8'hFE);
    send_word(ReqTick, 32'd4230, 8'hFE);        // button one press edge
    send_word(ReqTick, 32'd4300, 8'hFF);
    send_word(ReqTick, 32'd4330, 8'hFF);        // button one short press
    send_word(ReqTick, 32'd4400, 8'hFD);        // button two bounce
    send_word(ReqTick, 32'd4410, 8'hFF);
    send_word(ReqTick, 32'd4440, 8'hFF);
    send_word(ReqInit, 32'd5000, 8'hF8);        // init with all three down
    send_word(ReqTick, 32'd5000, 8'hF8);        // power hold hides the others
    send_word(ReqTick, 32'd5001, 8'hF8);        // then button one hold
    send_word(ReqTick, 32'd5002, 8'hF8);        // then button two hold
    send_word(ReqTick, 32'd5100, 8'h00);        // every port bit low
    send_word(ReqInit, 32'hFFFF_FFF0, 8'hFF);
    send_word(ReqTick, 32'hFFFF_FFF0, 8'hFD);
    send_word(ReqTick, 32'h0000_000E, 8'hFD);   // debounce elapses across the wrap
    send_word(ReqTick, 32'h0000_000F, 8'hFF);
    send_word(ReqTick, 32'h0000_002D, 8'hFF);   // short press just past the wrap
    send_word(ReqTick, 32'hFFFF_FFFF, 8'hFF);

    // zero debounce and zero holds: same-tick accept, hold on the next tick
    configure(16'd0, 16'd0, 16'd0, 3'd7, 3'd6, 3'd5);
    random_phase(140, 4);

    // everything at its maximum, all three buttons on one bit
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd3, 3'd3, 3'd3);
    random_phase(140, 16000);

    // back to reset values, timestamps wrapping partway through
    configure(DebounceReset, BtnHoldReset, PwrHoldReset,
              FirstBitReset, SecondBitReset, PowerBitReset);
    clock_ms = 32'hFFFF_F000;
    random_phase(140, 250);

    // short thresholds, each button on its own bit
    configure(16'd5, 16'd40, 16'd90, 3'd4, 3'd0, 3'd7);
    random_phase(140, 20);

    // random small setting, bits possibly shared
    begin
      logic [MsBits-1:0] bh;
      bh = 16'($urandom_range(1, 300));
      configure(16'($urandom_range(0, 40)), bh, 16'($urandom_range(1, 600)),
                3'($urandom), 3'($urandom), 3'($urandom));
      random_phase(140, bh / 4 + 2);
    end

    // lopsided: buttons need a minute, power holds at once; one/two share a bit
    configure(16'd2, 16'hFFFF, 16'd1, 3'd5, 3'd5, 3'd6);
    random_phase(125, 3000);

    drain();
    // give any stray extra result a chance to surface
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ three_button_debounce_short_hold.f @@
+incdir+rtl
rtl/tbdsh_pkg.sv
rtl/tbdsh_button.sv
rtl/three_button_debounce_short_hold.sv
sim/three_button_debounce_short_hold_checker.sv
sim/tb_three_button_debounce_short_hold.sv
